// ===== rtl/tpc_pkg.sv =====
`timescale 1ns / 1ps
package tpc_pkg;

   localparam int DIV_STEPS = 32;

   // csr register indexes
   localparam logic [1:0] CSR_TEMP_CAL  = 2'd0;
   localparam logic [1:0] CSR_PRES_CAL1 = 2'd1;
   localparam logic [1:0] CSR_PRES_CAL2 = 2'd2;
   localparam logic [1:0] CSR_PRES_CAL9 = 2'd3;

   localparam logic [31:0] T_OFFSET   = 32'd64000;
   localparam logic [31:0] P_FULL     = 32'd1048576;
   localparam logic [31:0] P_SCALE    = 32'd3125;
   localparam logic [31:0] P1_BIAS    = 32'd32768;
   localparam logic [31:0] T_ROUND    = 32'd128;

   typedef struct packed {
      logic [15:0] t1;
      logic [15:0] t2;
      logic [15:0] t3;
      logic [15:0] p1;
      logic [15:0] p2;
      logic [15:0] p3;
      logic [15:0] p4;
      logic [15:0] p5;
      logic [15:0] p6;
      logic [15:0] p7;
      logic [15:0] p8;
      logic [15:0] p9;
   } cal_type;

   // fields that ride alongside the division
   typedef struct packed {
      logic [31:0] temp;
      logic [31:0] fine;
      logic        big;
      logic        zero;
   } side_type;

   function automatic logic [31:0] sext16(input logic [15:0] x);
      return {{16{x[15]}}, x};
   endfunction

   function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned n);
      return 32'($signed(x) >>> n);
   endfunction

   function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] r;
      r = a * b;
      return r;
   endfunction

endpackage

// ===== rtl/tpc_front.sv =====
`timescale 1ns / 1ps
module tpc_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic [19:0]        raw_t,
   input  logic [19:0]        raw_p,
   input  tpc_pkg::cal_type   cal,
   output logic               out_valid,
   output logic [31:0]        out_dividend,
   output logic [31:0]        out_divisor,
   output tpc_pkg::side_type  out_side
);

   logic [9:0]  v_ff;
   logic [9:0]  v_in;

   logic [19:0] rt0_ff, rp0_ff;
   logic [31:0] m1_ff, dd1_ff;
   logic [19:0] rp1_ff;
   logic [31:0] at2_ff, m2_ff;
   logic [19:0] rp2_ff;
   logic [31:0] fine3_ff;
   logic [19:0] rp3_ff;
   logic [31:0] temp4_ff, fine4_ff, a4_ff;
   logic [19:0] rp4_ff;
   logic [31:0] temp5_ff, fine5_ff, qq5_ff, ma5_ff, mp5_ff;
   logic [19:0] rp5_ff;
   logic [31:0] temp6_ff, fine6_ff, b6_ff, m36_ff, ma6_ff, mp6_ff;
   logic [19:0] rp6_ff;
   logic [31:0] temp7_ff, fine7_ff, b7_ff, ap7_ff;
   logic [19:0] rp7_ff;
   logic [31:0] temp8_ff, fine8_ff, aa8_ff, num8_ff;
   logic [31:0] temp9_ff, fine9_ff, aa9_ff, pm9_ff;
   logic        zero9_ff;

   logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6;
   logic [31:0] x1, d1, fine5x, a4_in, q5;

   assign t1 = {16'd0, cal.t1};
   assign t2 = tpc_pkg::sext16(cal.t2);
   assign t3 = tpc_pkg::sext16(cal.t3);
   assign p1 = {16'd0, cal.p1};
   assign p2 = tpc_pkg::sext16(cal.p2);
   assign p3 = tpc_pkg::sext16(cal.p3);
   assign p4 = tpc_pkg::sext16(cal.p4);
   assign p5 = tpc_pkg::sext16(cal.p5);
   assign p6 = tpc_pkg::sext16(cal.p6);

   assign x1     = {15'd0, rt0_ff[19:3]} - {15'd0, cal.t1, 1'b0};
   assign d1     = {16'd0, rt0_ff[19:4]} - t1;
   assign fine5x = {fine3_ff[29:0], 2'b00} + fine3_ff;
   assign a4_in  = tpc_pkg::asr(fine3_ff, 1) - tpc_pkg::T_OFFSET;
   assign q5     = tpc_pkg::asr(a4_ff, 2);

   assign v_in = {v_ff[8:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      // capture
      rt0_ff <= raw_t;
      rp0_ff <= raw_p;
      // temperature products
      m1_ff  <= tpc_pkg::mul32(x1, t2);
      dd1_ff <= tpc_pkg::mul32(d1, d1);
      rp1_ff <= rp0_ff;
      at2_ff <= tpc_pkg::asr(m1_ff, 11);
      m2_ff  <= tpc_pkg::mul32(tpc_pkg::asr(dd1_ff, 12), t3);
      rp2_ff <= rp1_ff;
      fine3_ff <= at2_ff + tpc_pkg::asr(m2_ff, 14);
      rp3_ff   <= rp2_ff;
      // temperature result, pressure offset
      temp4_ff <= tpc_pkg::asr(fine5x + tpc_pkg::T_ROUND, 8);
      fine4_ff <= fine3_ff;
      a4_ff    <= a4_in;
      rp4_ff   <= rp3_ff;
      // pressure products
      qq5_ff   <= tpc_pkg::mul32(q5, q5);
      ma5_ff   <= tpc_pkg::mul32(a4_ff, p5);
      mp5_ff   <= tpc_pkg::mul32(p2, a4_ff);
      temp5_ff <= temp4_ff;
      fine5_ff <= fine4_ff;
      rp5_ff   <= rp4_ff;
      b6_ff    <= tpc_pkg::mul32(tpc_pkg::asr(qq5_ff, 11), p6);
      m36_ff   <= tpc_pkg::mul32(p3, tpc_pkg::asr(qq5_ff, 13));
      ma6_ff   <= ma5_ff;
      mp6_ff   <= mp5_ff;
      temp6_ff <= temp5_ff;
      fine6_ff <= fine5_ff;
      rp6_ff   <= rp5_ff;
      b7_ff    <= tpc_pkg::asr(b6_ff + {ma6_ff[30:0], 1'b0}, 2) + {p4[15:0], 16'd0};
      ap7_ff   <= tpc_pkg::asr(tpc_pkg::asr(m36_ff, 3) + tpc_pkg::asr(mp6_ff, 1), 18);
      temp7_ff <= temp6_ff;
      fine7_ff <= fine6_ff;
      rp7_ff   <= rp6_ff;
      // divisor and numerator
      aa8_ff   <= tpc_pkg::asr(tpc_pkg::mul32(tpc_pkg::P1_BIAS + ap7_ff, p1), 15);
      num8_ff  <= (tpc_pkg::P_FULL - {12'd0, rp7_ff}) - tpc_pkg::asr(b7_ff, 12);
      temp8_ff <= temp7_ff;
      fine8_ff <= fine7_ff;
      pm9_ff   <= tpc_pkg::mul32(num8_ff, tpc_pkg::P_SCALE);
      aa9_ff   <= aa8_ff;
      zero9_ff <= (aa8_ff == '0);
      temp9_ff <= temp8_ff;
      fine9_ff <= fine8_ff;
   end

   assign out_valid     = v_ff[9];
   // large dividend: divide first, double after
   assign out_dividend  = pm9_ff[31] ? pm9_ff : {pm9_ff[30:0], 1'b0};
   assign out_divisor   = aa9_ff;
   assign out_side.temp = temp9_ff;
   assign out_side.fine = fine9_ff;
   assign out_side.big  = pm9_ff[31];
   assign out_side.zero = zero9_ff;

endmodule

// ===== rtl/tpc_div.sv =====
`timescale 1ns / 1ps
module tpc_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic [31:0]        in_dividend,
   input  logic [31:0]        in_divisor,
   input  tpc_pkg::side_type  in_side,
   output logic               out_valid,
   output logic [31:0]        out_quotient,
   output tpc_pkg::side_type  out_side
);

   localparam int N = tpc_pkg::DIV_STEPS;

   logic               v_ff    [N];
   logic [31:0]        r_ff    [N];
   logic [31:0]        nq_ff   [N];
   logic [31:0]        d_ff    [N];
   tpc_pkg::side_type  side_ff [N];

   logic               v_in    [N];
   logic [31:0]        r_in    [N];
   logic [31:0]        nq_in   [N];
   logic [31:0]        d_in    [N];
   tpc_pkg::side_type  side_in [N];

   // one quotient bit per stage, restoring
   always_comb begin
      logic [31:0] r_prev, nq_prev, d_prev;
      logic [32:0] rs, diff;
      for (int i = 0; i < N; i++) begin
         if (i == 0) begin
            r_prev     = '0;
            nq_prev    = in_dividend;
            d_prev     = in_divisor;
            v_in[i]    = in_valid;
            side_in[i] = in_side;
         end else begin
            r_prev     = r_ff[i-1];
            nq_prev    = nq_ff[i-1];
            d_prev     = d_ff[i-1];
            v_in[i]    = v_ff[i-1];
            side_in[i] = side_ff[i-1];
         end
         rs       = {r_prev, nq_prev[31]};
         diff     = rs - {1'b0, d_prev};
         d_in[i]  = d_prev;
         if (rs >= {1'b0, d_prev}) begin
            r_in[i]  = diff[31:0];
            nq_in[i] = {nq_prev[30:0], 1'b1};
         end else begin
            r_in[i]  = rs[31:0];
            nq_in[i] = {nq_prev[30:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < N; i++) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else begin
            v_ff[i] <= v_in[i];
         end
         r_ff[i]    <= r_in[i];
         nq_ff[i]   <= nq_in[i];
         d_ff[i]    <= d_in[i];
         side_ff[i] <= side_in[i];
      end
   end

   assign out_valid    = v_ff[N-1];
   assign out_quotient = nq_ff[N-1];
   assign out_side     = side_ff[N-1];

endmodule

// ===== rtl/tpc_back.sv =====
`timescale 1ns / 1ps
module tpc_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic [31:0]        in_quotient,
   input  tpc_pkg::side_type  in_side,
   input  tpc_pkg::cal_type   cal,
   output logic               out_valid,
   output logic [31:0]        out_temp,
   output logic [31:0]        out_fine,
   output logic [31:0]        out_pressure,
   output logic               out_zero
);

   logic [2:0]  v_ff;
   logic [31:0] p_q;
   logic [31:0] m1_ff, mb1_ff, p1_ff, p2_ff, a2_ff, b2_ff;
   logic [31:0] pres_ff;
   tpc_pkg::side_type s1_ff, s2_ff, s3_ff;
   logic [31:0] p7, p8, p9, u;

   assign p7  = tpc_pkg::sext16(cal.p7);
   assign p8  = tpc_pkg::sext16(cal.p8);
   assign p9  = tpc_pkg::sext16(cal.p9);
   assign p_q = in_side.big ? {in_quotient[30:0], 1'b0} : in_quotient;
   assign u   = {3'd0, p_q[31:3]};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      m1_ff  <= tpc_pkg::mul32(u, u);
      mb1_ff <= tpc_pkg::mul32({2'd0, p_q[31:2]}, p8);
      p1_ff  <= p_q;
      s1_ff  <= in_side;
      a2_ff  <= tpc_pkg::asr(tpc_pkg::mul32(p9, {13'd0, m1_ff[31:13]}), 12);
      b2_ff  <= tpc_pkg::asr(mb1_ff, 13);
      p2_ff  <= p1_ff;
      s2_ff  <= s1_ff;
      pres_ff <= s2_ff.zero ? '0 : p2_ff + tpc_pkg::asr(a2_ff + b2_ff + p7, 4);
      s3_ff  <= s2_ff;
   end

   assign out_valid    = v_ff[2];
   assign out_temp     = s3_ff.temp;
   assign out_fine     = s3_ff.fine;
   assign out_pressure = pres_ff;
   assign out_zero     = s3_ff.zero;

endmodule

// ===== rtl/temperature_pressure_compensation.sv =====
`timescale 1ns / 1ps
// Temperature and pressure compensation, 32-bit integer form.
//
// Request channel: drive start high with req_raw_temperature and
// req_raw_pressure; the request is taken at that edge. busy is always low,
// so a new request may be issued every cycle.
// Result channel: rsp_valid is high for exactly one cycle with the
// temperature (0.01 degC), fine temperature, pressure (Pa) and the
// divisor_zero flag. Results come out in request order.
// Path from the accepting edge to the rsp_valid cycle:
// 10 stages of multiply/shift front end, 32 stages of a restoring divider
// (one quotient bit per stage), 3 stages of pressure correction.
// Throughput: one request per cycle, set by the fully pipelined divider.
// Calibration: csr_write_enable writes csr_wdata into register csr_index;
// writes are expected only while no request is in flight.
// Reset: synchronous; clears calibration and all valid bits in flight.
// The receiver cannot stall; results must be taken in their strobe cycle.
module temperature_pressure_compensation (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [19:0]        req_raw_temperature,
   input  logic [19:0]        req_raw_pressure,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_temperature_centi_c,
   output logic signed [31:0] rsp_fine_temperature,
   output logic [31:0]        rsp_pressure_pa,
   output logic               rsp_divisor_zero,
   input  logic               csr_write_enable,
   input  logic [1:0]         csr_index,
   input  logic [63:0]        csr_wdata
);

   logic [47:0] tcal_ff;
   logic [63:0] pcal1_ff, pcal2_ff;
   logic [15:0] pcal9_ff;
   tpc_pkg::cal_type cal;

   logic              fr_valid, dv_valid;
   logic [31:0]       fr_dividend, fr_divisor, dv_quotient;
   tpc_pkg::side_type fr_side, dv_side;
   logic [31:0]       bk_temp, bk_fine;

   // fully pipelined: never holds off a request
   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         tcal_ff  <= '0;
         pcal1_ff <= '0;
         pcal2_ff <= '0;
         pcal9_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            tpc_pkg::CSR_TEMP_CAL:  tcal_ff  <= csr_wdata[47:0];
            tpc_pkg::CSR_PRES_CAL1: pcal1_ff <= csr_wdata;
            tpc_pkg::CSR_PRES_CAL2: pcal2_ff <= csr_wdata;
            tpc_pkg::CSR_PRES_CAL9: pcal9_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // coefficient split
   assign cal.t1 = tcal_ff[15:0];
   assign cal.t2 = tcal_ff[31:16];
   assign cal.t3 = tcal_ff[47:32];
   assign cal.p1 = pcal1_ff[15:0];
   assign cal.p2 = pcal1_ff[31:16];
   assign cal.p3 = pcal1_ff[47:32];
   assign cal.p4 = pcal1_ff[63:48];
   assign cal.p5 = pcal2_ff[15:0];
   assign cal.p6 = pcal2_ff[31:16];
   assign cal.p7 = pcal2_ff[47:32];
   assign cal.p8 = pcal2_ff[63:48];
   assign cal.p9 = pcal9_ff;

   tpc_front u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (start & ~busy),
      .raw_t        (req_raw_temperature),
      .raw_p        (req_raw_pressure),
      .cal          (cal),
      .out_valid    (fr_valid),
      .out_dividend (fr_dividend),
      .out_divisor  (fr_divisor),
      .out_side     (fr_side)
   );

   tpc_div u_div (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (fr_valid),
      .in_dividend  (fr_dividend),
      .in_divisor   (fr_divisor),
      .in_side      (fr_side),
      .out_valid    (dv_valid),
      .out_quotient (dv_quotient),
      .out_side     (dv_side)
   );

   tpc_back u_back (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (dv_valid),
      .in_quotient  (dv_quotient),
      .in_side      (dv_side),
      .cal          (cal),
      .out_valid    (rsp_valid),
      .out_temp     (bk_temp),
      .out_fine     (bk_fine),
      .out_pressure (rsp_pressure_pa),
      .out_zero     (rsp_divisor_zero)
   );

   assign rsp_temperature_centi_c = $signed(bk_temp);
   assign rsp_fine_temperature    = $signed(bk_fine);

endmodule

// ===== rtl/tpc_checker.sv =====
`timescale 1ns / 1ps
module tpc_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_valid,
   input logic [31:0]        rsp_pressure_pa,
   input logic               rsp_divisor_zero
);

   localparam int LAT = 45;

   logic [LAT-1:0] hist_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff <= '0;
      end else begin
         hist_ff <= {hist_ff[LAT-2:0], start & ~busy};
      end
   end

   a_no_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid == hist_ff[LAT-1])
      else $error("result count or latency mismatch");

   a_zero_pres: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_divisor_zero) |-> (rsp_pressure_pa == 32'd0))
      else $error("zero divisor with nonzero pressure");

endmodule

bind temperature_pressure_compensation tpc_checker u_tpc_checker (.*);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;

   // ports
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [19:0] req_raw_temperature = '0;
   logic [19:0] req_raw_pressure = '0;
   logic        rsp_valid;
   logic signed [31:0] rsp_temperature_centi_c;
   logic signed [31:0] rsp_fine_temperature;
   logic [31:0] rsp_pressure_pa;
   logic        rsp_divisor_zero;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_index = tpc_pkg::CSR_TEMP_CAL;
   logic [63:0] csr_wdata = '0;

   temperature_pressure_compensation uut (.*);

   always #6 clock = ~clock;

   // one compensated sample
   typedef struct packed {
      logic [31:0] temp;
      logic [31:0] fine;
      logic [31:0] pres;
      logic        zero;
   } sample_result_type;

   // local copy of the calibration registers
   logic [47:0] cal_temp;
   logic [63:0] cal_pres1, cal_pres2;
   logic [15:0] cal_pres9;

   sample_result_type pending_results[$];
   int unsigned    error_count = 0;
   int unsigned    cycle_count = 0;
   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned LATENCY = 45;

   // arithmetic shift right on a 32-bit pattern
   function automatic logic [31:0] sra(input logic [31:0] x, input int n);
      return 32'($signed(x) >>> n);
   endfunction

   function automatic logic [31:0] sx(input logic [15:0] x);
      return {{16{x[15]}}, x};
   endfunction

   // compensation of one sample with the current calibration
   function automatic sample_result_type compensate(input logic [19:0] raw_t,
                                                    input logic [19:0] raw_p);
      logic [31:0] adc_t, adc_p, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
      logic [31:0] a, b, d, q, qq, fine, temp, p;
      sample_result_type r;
      adc_t = {12'd0, raw_t};
      adc_p = {12'd0, raw_p};
      t1 = {16'd0, cal_temp[15:0]};
      t2 = sx(cal_temp[31:16]);
      t3 = sx(cal_temp[47:32]);
      p1 = {16'd0, cal_pres1[15:0]};
      p2 = sx(cal_pres1[31:16]);
      p3 = sx(cal_pres1[47:32]);
      p4 = sx(cal_pres1[63:48]);
      p5 = sx(cal_pres2[15:0]);
      p6 = sx(cal_pres2[31:16]);
      p7 = sx(cal_pres2[47:32]);
      p8 = sx(cal_pres2[63:48]);
      p9 = sx(cal_pres9);
      // temperature
      a = sra(((adc_t >> 3) - (t1 << 1)) * t2, 11);
      d = (adc_t >> 4) - t1;
      b = sra(sra(d * d, 12) * t3, 14);
      fine = a + b;
      temp = sra(fine * 32'd5 + 32'd128, 8);
      // pressure
      a = sra(fine, 1) - 32'd64000;
      q = sra(a, 2);
      qq = q * q;
      b = sra(qq, 11) * p6;
      b = b + ((a * p5) << 1);
      b = sra(b, 2) + (p4 << 16);
      a = sra(sra(p3 * sra(qq, 13), 3) + sra(p2 * a, 1), 18);
      a = sra((32'd32768 + a) * p1, 15);
      r.zero = (a == 0);
      if (r.zero) begin
         p = 0;
      end else begin
         p = ((32'd1048576 - adc_p) - sra(b, 12)) * 32'd3125;
         // large dividend: divide first, then double
         if (p < 32'h8000_0000) p = (p << 1) / a;
         else p = (p / a) * 32'd2;
         a = sra(p9 * (((p >> 3) * (p >> 3)) >> 13), 12);
         b = sra((p >> 2) * p8, 13);
         p = p + sra(a + b + p7, 4);
      end
      r.temp = temp;
      r.fine = fine;
      r.pres = p;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("MISMATCH %s: got %h expected %h at cycle %0d", what, got, want,
               cycle_count);
      error_count++;
   endtask

   // response monitor: every strobe is checked against the oldest request
   always @(posedge clock) begin
      sample_result_type want;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected response", 32'd0, 32'd0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_temperature_centi_c !== want.temp)
               report_mismatch("temperature", rsp_temperature_centi_c, want.temp);
            if (rsp_fine_temperature !== want.fine)
               report_mismatch("fine temperature", rsp_fine_temperature, want.fine);
            if (rsp_pressure_pa !== want.pres)
               report_mismatch("pressure", rsp_pressure_pa, want.pres);
            if (rsp_divisor_zero !== want.zero)
               report_mismatch("divisor zero", {31'd0, rsp_divisor_zero},
                               {31'd0, want.zero});
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Simulation FAILED");
         $finish;
      end
   end

   // one register write; the enable stays high for back to back writes
   task automatic write_csr(input logic [1:0] idx, input logic [63:0] value);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         tpc_pkg::CSR_TEMP_CAL:  cal_temp  = value[47:0];
         tpc_pkg::CSR_PRES_CAL1: cal_pres1 = value;
         tpc_pkg::CSR_PRES_CAL2: cal_pres2 = value;
         tpc_pkg::CSR_PRES_CAL9: cal_pres9 = value[15:0];
         default: ;
      endcase
   endtask

   // all four registers, only while nothing is in flight
   task automatic write_calibration(input logic [63:0] tcal, input logic [63:0] pcal1,
                                    input logic [63:0] pcal2, input logic [63:0] pcal9);
      write_csr(tpc_pkg::CSR_TEMP_CAL, tcal);
      write_csr(tpc_pkg::CSR_PRES_CAL1, pcal1);
      write_csr(tpc_pkg::CSR_PRES_CAL2, pcal2);
      write_csr(tpc_pkg::CSR_PRES_CAL9, pcal9);
      csr_write_enable <= 1'b0;
   endtask

   task automatic drain;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   // issue one request; the expectation is queued at the accepting edge
   task automatic send_request(input logic [19:0] rt, input logic [19:0] rp,
                               input bit gaps);
      int n;
      if (gaps && $urandom_range(0, 5) == 0) begin
         start <= 1'b0;
         n = $urandom_range(1, 12);
         repeat (n) @(posedge clock);
      end
      start <= 1'b1;
      req_raw_temperature <= rt;
      req_raw_pressure <= rp;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_results.push_back(compensate(rt, rp));
   endtask

   task automatic idle_start;
      start <= 1'b0;
      @(posedge clock);
   endtask

   // typical datasheet-like calibration
   localparam logic [47:0] CAL_T_NOMINAL = {16'd50, 16'd26435, 16'd27504};
   localparam logic [63:0] CAL_P1_NOMINAL =
      {16'd2855, 16'hD0A8, 16'hD6D0, 16'd36477};
   localparam logic [63:0] CAL_P2_NOMINAL =
      {16'hF05D, 16'd15500, 16'hFFF9, 16'd140};
   localparam logic [15:0] CAL_P9_NOMINAL = 16'd6000;

   // directed requests
   typedef struct {
      logic [19:0]       rt;
      logic [19:0]       rp;
      bit                known;  // expected value typed in
      sample_result_type want;
   } directed_row_type;

   directed_row_type directed_rows[$];
   int unsigned   random_count;
   logic [63:0]   r64a, r64b, r64c;

   task automatic run_directed;
      foreach (directed_rows[i]) begin
         if (directed_rows[i].known) begin
            // typed expectation must agree with the predictor
            if (compensate(directed_rows[i].rt, directed_rows[i].rp)
                !== directed_rows[i].want)
               report_mismatch("directed row", 32'(i), 32'd0);
         end
         send_request(directed_rows[i].rt, directed_rows[i].rp, 1'b0);
      end
      idle_start();
   endtask

   function automatic directed_row_type row(input logic [19:0] rt,
                                            input logic [19:0] rp);
      directed_row_type r;
      r.rt = rt;
      r.rp = rp;
      r.known = 0;
      r.want = '0;
      return r;
   endfunction

   initial begin
      directed_row_type r;
      cal_temp = '0;
      cal_pres1 = '0;
      cal_pres2 = '0;
      cal_pres9 = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // after reset all coefficients are zero: P1 = 0 gives a zero divisor,
      // fine = 0, temperature rounds to 0
      r = row(20'hFFFFF, 20'h00000);
      r.known = 1;
      r.want = '{temp: 32'd0, fine: 32'd0, pres: 32'd0, zero: 1'b1};
      directed_rows.push_back(r);
      r.rt = 20'h00000;
      r.rp = 20'hFFFFF;
      directed_rows.push_back(r);
      run_directed();
      drain();

      // nominal calibration, field extremes; upper bits masked
      write_calibration({16'hABCD, CAL_T_NOMINAL}, CAL_P1_NOMINAL, CAL_P2_NOMINAL,
                        {48'hFFFF_0000_1234, CAL_P9_NOMINAL});
      directed_rows.delete();
      directed_rows.push_back(row(20'd519888, 20'd415148));
      directed_rows.push_back(row(20'd0, 20'd0));
      directed_rows.push_back(row(20'hFFFFF, 20'hFFFFF));
      directed_rows.push_back(row(20'd0, 20'hFFFFF));
      directed_rows.push_back(row(20'hFFFFF, 20'd0));
      directed_rows.push_back(row(20'h55555, 20'hAAAAA));
      directed_rows.push_back(row(20'hAAAAA, 20'h55555));
      run_directed();
      drain();

      // extreme coefficients: large dividend path and wraparound
      write_calibration(64'({16'h8000, 16'h7FFF, 16'hFFFF}),
                        {16'h7FFF, 16'h8000, 16'h7FFF, 16'd1},
                        {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF},
                        64'h8000);
      directed_rows.delete();
      directed_rows.push_back(row(20'd0, 20'd0));
      directed_rows.push_back(row(20'hFFFFF, 20'hFFFFF));
      directed_rows.push_back(row(20'h80000, 20'h7FFFF));
      directed_rows.push_back(row(20'h12345, 20'h00001));
      run_directed();
      drain();

      write_calibration(64'h7FFF_8000_0000,
                        {16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF},
                        64'hFFFF_FFFF_FFFF_FFFF,
                        64'h7FFF);
      directed_rows.delete();
      directed_rows.push_back(row(20'd0, 20'hFFFFF));
      directed_rows.push_back(row(20'hFFFFF, 20'd0));
      directed_rows.push_back(row(20'h40000, 20'h40000));
      run_directed();
      drain();

      // random phases; each phase has its own calibration
      for (int phase = 0; phase < 10; phase++) begin
         if (phase % 3 == 0) begin
            // nominal calibration with small jitter keeps results realistic
            write_calibration(64'(CAL_T_NOMINAL ^ 48'($urandom_range(0, 255))),
                              CAL_P1_NOMINAL ^ 64'($urandom_range(0, 255)),
                              CAL_P2_NOMINAL ^ 64'($urandom_range(0, 255)),
                              64'(CAL_P9_NOMINAL ^ 16'($urandom_range(0, 255))));
         end else begin
            r64a = {$urandom, $urandom};
            r64b = {$urandom, $urandom};
            r64c = {$urandom, $urandom};
            write_calibration(r64a, r64b, r64c, 64'($urandom));
         end
         random_count = 120;
         for (int k = 0; k < random_count; k++) begin
            // the last phase runs back to back with no gaps
            if ($urandom_range(0, 3) == 0)
               send_request(($urandom_range(0, 1) ? 20'hFFFFF : 20'h0),
                            20'($urandom), phase < 9);
            else
               send_request(20'($urandom), 20'($urandom), phase < 9);
         end
         idle_start();
         drain();
      end

      if (error_count == 0 && pending_results.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
